// File: hdl/lsc_pkg.sv
// lsc_pkg: sizes, operation codes and shared types of the lottery scheduler
// used by the cell modules, the top level and the port checker
package lsc_pkg;

  // list and cpu sizes
  localparam int READY_DEPTH   = 64;
  localparam int BLOCKED_DEPTH = 16;
  localparam int CPU_COUNT     = 4;

  localparam int TICKETS_PER_TICK = 1000;

  // field widths
  localparam int PID_W = 8;
  localparam int QL_W  = 10;
  localparam int RW_W  = 32;

  // derived widths
  localparam int RCNT_W = $clog2(READY_DEPTH + 1);
  localparam int RIDX_W = $clog2(READY_DEPTH);
  localparam int BCNT_W = $clog2(BLOCKED_DEPTH + 1);
  localparam int BIDX_W = (BLOCKED_DEPTH > 1) ? $clog2(BLOCKED_DEPTH) : 1;
  localparam int CPU_W  = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int PER_W  = QL_W + $clog2(TICKETS_PER_TICK);
  localparam int TOT_W  = PER_W + RCNT_W;
  localparam int BIT_W  = $clog2(RW_W);

  // operation codes
  localparam logic [2:0] OP_LOAD    = 3'd0;
  localparam logic [2:0] OP_UNBLOCK = 3'd1;
  localparam logic [2:0] OP_TICK    = 3'd2;
  localparam logic [2:0] OP_BLOCK   = 3'd3;
  localparam logic [2:0] OP_EXIT    = 3'd4;

  localparam logic [QL_W-1:0] QUANTUM_RESET = QL_W'(10);

  // control sent to every cell of a chain
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

  // one blocked record
  typedef struct packed {
    logic [PID_W-1:0] pid;
    logic [QL_W-1:0]  left;
  } blk_entry_t;

endpackage

// File: hdl/lsc_ready_cell.sv
// lsc_ready_cell: one cell of the ready list chain, holds one pid
// depends on lsc_pkg
module lsc_ready_cell (
  input  logic                    clk,
  input  lsc_pkg::cell_ctl_t      ctl,
  input  logic [lsc_pkg::PID_W-1:0] load_pid,
  input  logic [lsc_pkg::PID_W-1:0] next_pid,
  output logic [lsc_pkg::PID_W-1:0] pid
);
  import lsc_pkg::*;

  // load wins over the shift from the upper neighbor
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      pid <= load_pid;
    end else if (ctl.shift) begin
      pid <= next_pid;
    end
  end

endmodule

// File: hdl/lsc_blocked_cell.sv
// lsc_blocked_cell: one cell of the blocked list chain, holds pid and ticks left
// depends on lsc_pkg
module lsc_blocked_cell (
  input  logic                clk,
  input  lsc_pkg::cell_ctl_t  ctl,
  input  lsc_pkg::blk_entry_t load_entry,
  input  lsc_pkg::blk_entry_t next_entry,
  output lsc_pkg::blk_entry_t entry
);
  import lsc_pkg::*;

  // load wins over the shift from the upper neighbor
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      entry <= load_entry;
    end else if (ctl.shift) begin
      entry <= next_entry;
    end
  end

endmodule

// File: hdl/lottery_scheduler_compensation.sv
// lottery_scheduler_compensation: top level, sequencer, draw arithmetic and
// the ready and blocked cell chains; depends on lsc_pkg and both cell modules
//
// channel   signals                                   direction
// input     in_valid in_ready operation cpu pid       in
//           random_word
// result    out_valid out_ready out_cpu out_pid       out
//           out_idle
// config    cfg_we cfg_wdata (quantum_ticks)          in
//
// one item at a time; in_ready is high only while the sequencer waits.
// load and ignored codes finish in the idle state; a tick that keeps its process
// passes through the output state. a draw: the multiply states, the bit serial
// modulo over each bit of the random word, then two passes through the ready chain.
// unblock: one pass over the blocked records, entering the copy state for each
// record that adds copies, which adds the ready copies one at a time.
// the lists start empty through their counts, no clearing pass after reset;
// a result waiting on out_ready holds the sequencer in its output state.
module lottery_scheduler_compensation (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [lsc_pkg::QL_W-1:0]   cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2:0]                 operation,
  input  logic [1:0]                 cpu,
  input  logic [lsc_pkg::PID_W-1:0]  pid,
  input  logic [lsc_pkg::RW_W-1:0]   random_word,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_cpu,
  output logic [lsc_pkg::PID_W-1:0]  out_pid,
  output logic                       out_idle
);
  import lsc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_UNBLK, S_COPY, S_MUL1, S_MUL2, S_MOD, S_WALK, S_PURGE, S_OUT
  } state_t;

  state_t state;

  logic [QL_W-1:0]   quantum_ticks;
  logic [RCNT_W-1:0] rcount;
  logic [BCNT_W-1:0] bcount;
  logic [QL_W-1:0]   ql       [CPU_COUNT];
  logic [PID_W-1:0]  run_pid  [CPU_COUNT];
  logic              run_idle [CPU_COUNT];

  logic [CPU_W-1:0]  cur_cpu;
  logic [PID_W-1:0]  cur_pid;
  logic [RW_W-1:0]   rword;
  logic [PER_W-1:0]  per;
  logic [TOT_W-1:0]  dsr;
  logic [TOT_W-1:0]  rem;
  logic [TOT_W-1:0]  acc;
  logic [RCNT_W-1:0] step;
  logic [RCNT_W-1:0] kept;
  logic [PID_W-1:0]  win;
  logic              found;
  logic [BIT_W-1:0]  bit_cnt;
  logic [QL_W-1:0]   copy_left;
  logic              copied;
  logic [BCNT_W-1:0] bstep;
  logic [BCNT_W-1:0] bkept;

  // chain storage
  logic [PID_W-1:0] rpid [READY_DEPTH];
  blk_entry_t       bent [BLOCKED_DEPTH];

  logic [CPU_W-1:0] in_c;
  logic             cpu_ok;
  logic             accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_c     = cpu[CPU_W-1:0];
  assign cpu_ok   = (int'(cpu) < CPU_COUNT);

  // bit serial modulo step
  logic [TOT_W:0]   rem_sh;
  logic [TOT_W:0]   rem_diff;
  logic [TOT_W-1:0] rem_next;

  always_comb begin
    rem_sh   = {rem, rword[RW_W-1]};
    rem_diff = rem_sh - {1'b0, dsr};
    if (rem_sh >= {1'b0, dsr}) begin
      rem_next = rem_diff[TOT_W-1:0];
    end else begin
      rem_next = rem_sh[TOT_W-1:0];
    end
  end

  // ready chain control
  logic              r_shift;
  logic              r_wr;
  logic [RIDX_W-1:0] r_waddr;
  logic [PID_W-1:0]  r_wdata;
  logic [PID_W-1:0]  r_head;
  logic [RCNT_W-1:0] r_rot;
  logic              r_last;

  assign r_head = rpid[0];
  assign r_rot  = rcount - RCNT_W'(1) - step + kept;
  assign r_last = (step == rcount - RCNT_W'(1));

  always_comb begin
    r_shift = 1'b0;
    r_wr    = 1'b0;
    r_waddr = rcount[RIDX_W-1:0];
    r_wdata = pid;
    case (state)
      S_IDLE: begin
        if (accept && (operation == OP_LOAD) && (rcount < READY_DEPTH)) begin
          r_wr = 1'b1;
        end else if (accept && (operation == OP_TICK) && cpu_ok && !run_idle[in_c]
                     && (ql[in_c] == QL_W'(1)) && (rcount < READY_DEPTH)) begin
          r_wr    = 1'b1;
          r_wdata = run_pid[in_c];
        end
      end
      S_COPY: begin
        r_wr    = (rcount < READY_DEPTH);
        r_wdata = cur_pid;
      end
      S_WALK: begin
        r_shift = 1'b1;
        r_wr    = 1'b1;
        r_waddr = r_rot[RIDX_W-1:0];
        r_wdata = r_head;
      end
      S_PURGE: begin
        r_shift = 1'b1;
        r_wr    = (r_head != win);
        r_waddr = r_rot[RIDX_W-1:0];
        r_wdata = r_head;
      end
      default: ;
    endcase
  end

  // ready cells
  for (genvar i = 0; i < READY_DEPTH; i++) begin : g_ready
    cell_ctl_t ctl;
    assign ctl.shift = r_shift;
    assign ctl.load  = r_wr && (r_waddr == RIDX_W'(i));
    lsc_ready_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .load_pid (r_wdata),
      .next_pid (rpid[(i < READY_DEPTH - 1) ? i + 1 : i]),
      .pid      (rpid[i])
    );
  end

  // blocked chain control
  logic              b_shift;
  logic              b_wr;
  logic [BIDX_W-1:0] b_waddr;
  blk_entry_t        b_wdata;
  blk_entry_t        b_head;
  logic [BCNT_W-1:0] b_rot;
  logic              b_match;
  logic              b_copy;

  assign b_head  = bent[0];
  assign b_rot   = bcount - BCNT_W'(1) - bstep + bkept;
  assign b_match = (b_head.pid == cur_pid);
  assign b_copy  = b_match && !copied && (b_head.left != '0) && (rcount < READY_DEPTH);

  always_comb begin
    b_shift = 1'b0;
    b_wr    = 1'b0;
    b_waddr = bcount[BIDX_W-1:0];
    b_wdata = b_head;
    case (state)
      S_IDLE: begin
        if (accept && (operation == OP_BLOCK) && cpu_ok && !run_idle[in_c]
            && (bcount < BLOCKED_DEPTH)) begin
          b_wr         = 1'b1;
          b_wdata.pid  = run_pid[in_c];
          b_wdata.left = ql[in_c] - QL_W'(1);
        end
      end
      S_UNBLK: begin
        if (!b_copy) begin
          b_shift = 1'b1;
          b_wr    = !b_match;
          b_waddr = b_rot[BIDX_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // blocked cells
  for (genvar j = 0; j < BLOCKED_DEPTH; j++) begin : g_blocked
    cell_ctl_t ctl;
    assign ctl.shift = b_shift;
    assign ctl.load  = b_wr && (b_waddr == BIDX_W'(j));
    lsc_blocked_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .load_entry (b_wdata),
      .next_entry (bent[(j < BLOCKED_DEPTH - 1) ? j + 1 : j]),
      .entry      (bent[j])
    );
  end

  // sequencer, per cpu state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      quantum_ticks <= QUANTUM_RESET;
      rcount        <= '0;
      bcount        <= '0;
      out_valid     <= 1'b0;
      for (int c = 0; c < CPU_COUNT; c++) begin
        ql[c]       <= '0;
        run_pid[c]  <= '0;
        run_idle[c] <= 1'b1;
      end
    end else begin
      if (cfg_we) begin
        quantum_ticks <= cfg_wdata;
      end
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cur_cpu <= in_c;
            cur_pid <= pid;
            rword   <= random_word;
            case (operation)
              OP_LOAD: begin
                if (rcount < READY_DEPTH) begin
                  rcount <= rcount + RCNT_W'(1);
                end
              end
              OP_UNBLOCK: begin
                if (bcount != '0) begin
                  bstep  <= '0;
                  bkept  <= '0;
                  copied <= 1'b0;
                  state  <= S_UNBLK;
                end
              end
              OP_TICK: begin
                if (cpu_ok) begin
                  if (run_idle[in_c]) begin
                    state <= S_MUL1;
                  end else begin
                    ql[in_c] <= ql[in_c] - QL_W'(1);
                    if (ql[in_c] == QL_W'(1)) begin
                      if (rcount < READY_DEPTH) begin
                        rcount <= rcount + RCNT_W'(1);
                      end
                      state <= S_MUL1;
                    end else begin
                      state <= S_OUT;
                    end
                  end
                end
              end
              OP_BLOCK: begin
                if (cpu_ok) begin
                  if (!run_idle[in_c]) begin
                    ql[in_c] <= ql[in_c] - QL_W'(1);
                    if (bcount < BLOCKED_DEPTH) begin
                      bcount <= bcount + BCNT_W'(1);
                    end
                  end
                  state <= S_MUL1;
                end
              end
              OP_EXIT: begin
                if (cpu_ok) begin
                  state <= S_MUL1;
                end
              end
              default: ;
            endcase
          end
        end
        // walk the blocked chain once, re-adding copies for matches
        S_UNBLK: begin
          if (b_copy) begin
            copy_left <= b_head.left;
            state     <= S_COPY;
          end else begin
            copied <= 1'b0;
            if (!b_match) begin
              bkept <= bkept + BCNT_W'(1);
            end
            bstep <= bstep + BCNT_W'(1);
            if (bstep == bcount - BCNT_W'(1)) begin
              bcount <= b_match ? bkept : bkept + BCNT_W'(1);
              state  <= S_IDLE;
            end
          end
        end
        S_COPY: begin
          if (rcount < READY_DEPTH) begin
            rcount <= rcount + RCNT_W'(1);
          end
          copy_left <= copy_left - QL_W'(1);
          if ((copy_left == QL_W'(1)) || (rcount >= READY_DEPTH - 1)) begin
            copied <= 1'b1;
            state  <= S_UNBLK;
          end
        end
        // draw: tickets per entry, then modulus; an empty ready list leaves the cpu idle
        S_MUL1: begin
          if (rcount == '0) begin
            run_idle[cur_cpu] <= 1'b1;
            run_pid[cur_cpu]  <= '0;
            state             <= S_OUT;
          end else begin
            per   <= PER_W'(quantum_ticks * TICKETS_PER_TICK);
            state <= S_MUL2;
          end
        end
        S_MUL2: begin
          dsr     <= TOT_W'(TOT_W'(per) * TOT_W'(rcount)) + TOT_W'(1);
          rem     <= '0;
          bit_cnt <= '0;
          state   <= S_MOD;
        end
        S_MOD: begin
          rem     <= rem_next;
          rword   <= rword << 1;
          bit_cnt <= bit_cnt + BIT_W'(1);
          if (bit_cnt == BIT_W'(RW_W - 1)) begin
            step  <= '0;
            kept  <= '0;
            acc   <= TOT_W'(per);
            found <= 1'b0;
            state <= S_WALK;
          end
        end
        // rotate the whole list once, picking the entry whose range holds rem, else the last
        S_WALK: begin
          if (!found && ((rem < acc) || r_last)) begin
            win   <= r_head;
            found <= 1'b1;
          end
          acc <= acc + TOT_W'(per);
          if (r_last) begin
            step  <= '0;
            kept  <= '0;
            state <= S_PURGE;
          end else begin
            step <= step + RCNT_W'(1);
            kept <= kept + RCNT_W'(1);
          end
        end
        // rotate again, dropping every copy of the winner
        S_PURGE: begin
          if (r_head != win) begin
            kept <= kept + RCNT_W'(1);
          end
          step <= step + RCNT_W'(1);
          if (r_last) begin
            rcount            <= (r_head != win) ? kept + RCNT_W'(1) : kept;
            ql[cur_cpu]       <= quantum_ticks;
            run_pid[cur_cpu]  <= win;
            run_idle[cur_cpu] <= 1'b0;
            state             <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_cpu   <= 2'(cur_cpu);
            out_pid   <= run_idle[cur_cpu] ? '0 : run_pid[cur_cpu];
            out_idle  <= run_idle[cur_cpu];
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/lsc_checker.sv
// lsc_checker: port level checks of the lottery scheduler and its bind
// depends on lsc_pkg and the top level lottery_scheduler_compensation
module lsc_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [2:0]                operation,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [1:0]                out_cpu,
  input logic [lsc_pkg::PID_W-1:0] out_pid,
  input logic                      out_idle
);
  import lsc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({out_cpu, out_pid, out_idle}))
    else $error("result changed while stalled");

  // an idle cpu reports pid zero
  a_idle_pid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_idle |-> out_pid == '0)
    else $error("idle result with nonzero pid");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result right after reset");

  // a load item makes no result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (operation == OP_LOAD) && !out_valid |=> !out_valid)
    else $error("load produced a result");

endmodule

bind lottery_scheduler_compensation lsc_checker u_lsc_checker (.*);
